// File: rtl/ebc_pkg.sv
// Shared types and constants for the eight-bit execute core.
`timescale 1ns / 1ps
`default_nettype none
package ebc_pkg;

	// condition flags, carry in bit 0
	typedef struct packed {
		logic parity;
		logic sign;
		logic zero;
		logic carry;
	} flags_t;

	// ALU operation codes, opcode bits 5..3
	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_ADC = 3'd1,
		ALU_SUB = 3'd2,
		ALU_SBB = 3'd3,
		ALU_AND = 3'd4,
		ALU_XOR = 3'd5,
		ALU_OR  = 3'd6,
		ALU_CMP = 3'd7
	} alu_op_t;

	// port access kinds
	localparam logic [1:0] PORT_NONE = 2'd0;
	localparam logic [1:0] PORT_IN   = 2'd1;
	localparam logic [1:0] PORT_OUT  = 2'd2;

	// register indexes; index 7 selects memory at H:L
	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_H = 3'd5;
	localparam logic [2:0] REG_L = 3'd6;
	localparam logic [2:0] REG_M = 3'd7;

	// opcode groups, bits 7..6
	localparam logic [1:0] GRP_MISC = 2'd0;
	localparam logic [1:0] GRP_JMP  = 2'd1;
	localparam logic [1:0] GRP_ALU  = 2'd2;
	localparam logic [1:0] GRP_MOV  = 2'd3;

	// low opcode field in the miscellaneous group
	localparam logic [2:0] SUB_INR  = 3'd0;
	localparam logic [2:0] SUB_DCR  = 3'd1;
	localparam logic [2:0] SUB_ROT  = 3'd2;
	localparam logic [2:0] SUB_RET  = 3'd3;
	localparam logic [2:0] SUB_ALUI = 3'd4;
	localparam logic [2:0] SUB_RST  = 3'd5;
	localparam logic [2:0] SUB_MVI  = 3'd6;
	localparam logic [2:0] SUB_RETU = 3'd7;

	localparam int OUT_ADDR_W = 14;

endpackage
`default_nettype wire

// File: rtl/ebc_alu.sv
// Eight-bit ALU: add, subtract with borrow, logic operations and compare.
`timescale 1ns / 1ps
`default_nettype none
module ebc_alu (
	input  wire ebc_pkg::alu_op_t op,
	input  wire logic [7:0]       a,
	input  wire logic [7:0]       b,
	input  wire ebc_pkg::flags_t  flags_in,
	output logic [7:0]            result,
	output ebc_pkg::flags_t       flags_out
);

	logic [8:0] r;
	logic [8:0] cin;

	always_comb begin
		cin = {8'd0, flags_in.carry};
		unique case (op)
			ebc_pkg::ALU_ADD: r = {1'b0, a} + {1'b0, b};
			ebc_pkg::ALU_ADC: r = {1'b0, a} + {1'b0, b} + cin;
			ebc_pkg::ALU_SUB: r = {1'b0, a} - {1'b0, b};
			ebc_pkg::ALU_SBB: r = {1'b0, a} - {1'b0, b} - cin;
			ebc_pkg::ALU_AND: r = {1'b0, a & b};
			ebc_pkg::ALU_XOR: r = {1'b0, a ^ b};
			ebc_pkg::ALU_OR:  r = {1'b0, a | b};
			ebc_pkg::ALU_CMP: r = {1'b0, a} - {1'b0, b};
			default:          r = 9'd0;
		endcase
		result           = r[7:0];
		flags_out.carry  = r[8];
		flags_out.zero   = (r[7:0] == 8'd0);
		flags_out.sign   = r[7];
		flags_out.parity = ~^r[7:0];
	end

endmodule
`default_nettype wire

// File: rtl/eight_bit_cpu_execute_core.sv
// Execute core top level: decode, register file, PC stack and result register.
`timescale 1ns / 1ps
`default_nettype none
// Executes one instruction per item. Each item carries the opcode, both following
// instruction bytes, the memory byte at H:L and the input-port byte; the result item
// reports the new PC, any memory store or port access, H:L, flags and A. An item is
// taken every cycle while the result side keeps up: decode, ALU and the
// stack/register-file update sit between the input handshake and a single result
// register; the result follows in the next cycle, at one item per clock. The PC is
// the top of a STACK_DEPTH-entry address stack held in a top-of-stack register plus
// a small register array written once and read once per item.
module eight_bit_cpu_execute_core #(
	parameter int STACK_DEPTH  = 8,
	parameter int ADDRESS_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode, operand_low, operand_high, mem_byte, port_in_data
	input  wire logic [39:0] s_tdata,
	// int_request
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// next_pc, write_address, write_data, port_number, port_out_data, hl_pointer,
	// flag_bits, accumulator, zero pad
	output logic [79:0]      m_tdata,
	// mem_write, port_access, halted
	output logic [3:0]       m_tuser
);

	localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
	localparam logic [15:0] HL_MASK = 16'((17'd1 << ADDRESS_BITS) - 17'd1);

	logic [7:0]              regs_q [7];
	ebc_pkg::flags_t         flags_q;
	logic [ADDRESS_BITS-1:0] stack_q [STACK_DEPTH];
	logic [ADDRESS_BITS-1:0] top_q;
	logic [SP_W-1:0]         sp_q;

	logic       ovld_q;
	logic [79:0] odata_q;
	logic [3:0]  ouser_q;
	logic        in_fire;

	logic [7:0] opc, lo, hi, mbyte, pin;
	logic       frozen;
	logic [1:0] grp;
	logic [2:0] dst, src;
	logic [7:0] a, src_val, dst_val;
	logic       take;

	logic [1:0]              npc_steps;
	logic [ADDRESS_BITS-1:0] pc_inc, top_n, jmp_addr, rst_addr;
	logic [SP_W-1:0]         sp_inc, sp_dec, sp_n;

	logic            alu_en;
	logic [2:0]      alu_sel;
	logic [7:0]      alu_b, alu_res;
	ebc_pkg::flags_t alu_flags, flags_n;

	logic       reg_we;
	logic [2:0] reg_wa;
	logic [7:0] reg_wd, idv;

	logic        mem_write, halted;
	logic [7:0]  wdata, port_data;
	logic [1:0]  port_acc;
	logic [4:0]  port_no;
	logic [15:0] hl_before, hl_after, pc16;
	logic [7:0]  h_n, l_n, a_n;

	assign opc    = s_tdata[7:0];
	assign lo     = s_tdata[15:8];
	assign hi     = s_tdata[23:16];
	assign mbyte  = s_tdata[31:24];
	assign pin    = s_tdata[39:32];
	assign frozen = s_tuser;
	assign grp    = opc[7:6];
	assign dst    = opc[5:3];
	assign src    = opc[2:0];
	assign a      = regs_q[ebc_pkg::REG_A];

	assign s_tready = !ovld_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	assign src_val = (src == ebc_pkg::REG_M) ? mbyte : regs_q[src];
	assign dst_val = (dst == ebc_pkg::REG_M) ? 8'd0 : regs_q[dst];
	// unconditional when bit 2 set, else true/false sense chosen by bit 5
	assign take    = opc[2] || (opc[5] ? flags_q[opc[4:3]] : !flags_q[opc[4:3]]);

	assign sp_inc   = (sp_q == SP_LAST) ? '0 : sp_q + SP_W'(1);
	assign sp_dec   = (sp_q == '0) ? SP_LAST : sp_q - SP_W'(1);
	assign jmp_addr = ADDRESS_BITS'({2'b00, hi[5:0], lo});
	assign rst_addr = ADDRESS_BITS'({10'd0, opc[5:3], 3'b000});
	assign hl_before = {regs_q[ebc_pkg::REG_H], regs_q[ebc_pkg::REG_L]} & HL_MASK;

	ebc_alu u_alu (
		.op       (ebc_pkg::alu_op_t'(alu_sel)),
		.a        (a),
		.b        (alu_b),
		.flags_in (flags_q),
		.result   (alu_res),
		.flags_out(alu_flags)
	);

	always_comb begin
		npc_steps = 2'd1;
		alu_en    = 1'b0;
		alu_sel   = dst;
		alu_b     = src_val;
		reg_we    = 1'b0;
		reg_wa    = dst;
		reg_wd    = 8'd0;
		flags_n   = flags_q;
		sp_n      = sp_q;
		mem_write = 1'b0;
		wdata     = 8'd0;
		port_acc  = ebc_pkg::PORT_NONE;
		port_no   = 5'd0;
		port_data = 8'd0;
		halted    = 1'b0;
		idv       = (src[0]) ? dst_val - 8'd1 : dst_val + 8'd1;
		top_n     = '0;

		unique case (grp)
			ebc_pkg::GRP_MISC: begin
				unique case (src)
					ebc_pkg::SUB_INR, ebc_pkg::SUB_DCR: begin
						if (dst == ebc_pkg::REG_A) begin
							halted = 1'b1;
						end else if (dst != ebc_pkg::REG_M) begin
							reg_we         = 1'b1;
							reg_wd         = idv;
							flags_n.zero   = (idv == 8'd0);
							flags_n.sign   = idv[7];
							flags_n.parity = ~^idv;
						end
					end
					ebc_pkg::SUB_ROT: begin
						if (!dst[2]) begin
							reg_we = 1'b1;
							reg_wa = ebc_pkg::REG_A;
							unique case (dst[1:0])
								2'd0: reg_wd = {a[6:0], a[7]};
								2'd1: reg_wd = {a[0], a[7:1]};
								2'd2: reg_wd = {a[6:0], flags_q.carry};
								default: reg_wd = {flags_q.carry, a[7:1]};
							endcase
							flags_n.carry = dst[0] ? a[0] : a[7];
						end
					end
					ebc_pkg::SUB_RET, ebc_pkg::SUB_RETU: begin
						if (take) sp_n = sp_dec;
					end
					ebc_pkg::SUB_ALUI: begin
						npc_steps = 2'd2;
						alu_en    = 1'b1;
						alu_b     = lo;
					end
					ebc_pkg::SUB_RST: begin
						sp_n = sp_inc;
					end
					default: begin
						npc_steps = 2'd2;
						if (dst == ebc_pkg::REG_M) begin
							mem_write = 1'b1;
							wdata     = lo;
						end else begin
							reg_we = 1'b1;
							reg_wd = lo;
						end
					end
				endcase
			end
			ebc_pkg::GRP_JMP: begin
				if (opc[0]) begin
					port_no   = opc[5:1];
					port_data = a;
					if (opc[5:4] == 2'd0) begin
						port_acc = ebc_pkg::PORT_IN;
						reg_we   = 1'b1;
						reg_wa   = ebc_pkg::REG_A;
						reg_wd   = pin;
					end else begin
						port_acc = ebc_pkg::PORT_OUT;
					end
				end else begin
					npc_steps = 2'd3;
					if (take && opc[1]) sp_n = sp_inc;
				end
			end
			ebc_pkg::GRP_ALU: begin
				alu_en = 1'b1;
			end
			default: begin
				if (dst == ebc_pkg::REG_M && src == ebc_pkg::REG_M) begin
					halted = 1'b1;
				end else if (dst == ebc_pkg::REG_M) begin
					mem_write = 1'b1;
					wdata     = src_val;
				end else begin
					reg_we = 1'b1;
					reg_wd = src_val;
				end
			end
		endcase

		if (alu_en) begin
			flags_n = alu_flags;
			if (alu_sel != ebc_pkg::ALU_CMP) begin
				reg_we = 1'b1;
				reg_wa = ebc_pkg::REG_A;
				reg_wd = alu_res;
			end
		end

		if (frozen) npc_steps = 2'd0;
		pc_inc = top_q + ADDRESS_BITS'(npc_steps);

		// new top of stack
		top_n = pc_inc;
		if (grp == ebc_pkg::GRP_MISC && (src == ebc_pkg::SUB_RET || src == ebc_pkg::SUB_RETU)
				&& take) begin
			top_n = stack_q[sp_dec];
		end else if (grp == ebc_pkg::GRP_MISC && src == ebc_pkg::SUB_RST) begin
			top_n = rst_addr;
		end else if (grp == ebc_pkg::GRP_JMP && !opc[0] && take) begin
			top_n = jmp_addr;
		end

		h_n = (reg_we && reg_wa == ebc_pkg::REG_H) ? reg_wd : regs_q[ebc_pkg::REG_H];
		l_n = (reg_we && reg_wa == ebc_pkg::REG_L) ? reg_wd : regs_q[ebc_pkg::REG_L];
		a_n = (reg_we && reg_wa == ebc_pkg::REG_A) ? reg_wd : a;
		hl_after = {h_n, l_n} & HL_MASK;
		pc16     = 16'(top_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) regs_q[i] <= 8'd0;
			for (int i = 0; i < STACK_DEPTH; i++) stack_q[i] <= '0;
			flags_q <= '0;
			top_q   <= '0;
			sp_q    <= '0;
			ovld_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				if (reg_we) regs_q[reg_wa] <= reg_wd;
				flags_q <= flags_n;
				// park the advanced PC so the entry is current once sp moves on
				stack_q[sp_q] <= pc_inc;
				top_q <= top_n;
				sp_q  <= sp_n;
			end
			if (in_fire) ovld_q <= 1'b1;
			else if (m_tready) ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			odata_q <= {5'd0, a_n, flags_n, hl_after[ebc_pkg::OUT_ADDR_W-1:0], port_data,
				port_no, wdata, mem_write ? hl_before[ebc_pkg::OUT_ADDR_W-1:0] : 14'd0,
				pc16[ebc_pkg::OUT_ADDR_W-1:0]};
			ouser_q <= {halted, port_acc, mem_write};
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_LAST) else $error("stack pointer out of range");
	a_store_no_port: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && ouser_q[0] |-> ouser_q[2:1] == ebc_pkg::PORT_NONE && !ouser_q[3])
		else $error("store and port access in one item");
	a_port_code: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q |-> ouser_q[2:1] != 2'd3) else $error("bad port access code");
	a_frozen_pc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && frozen && sp_n == sp_q && top_n == pc_inc |=> top_q == $past(top_q))
		else $error("PC advanced while interrupt pending");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the eight-bit execute core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import ebc_pkg::*;

	typedef struct {
		bit [13:0] pc;
		bit        mw;
		bit [13:0] wa;
		bit [7:0]  wd;
		bit [1:0]  pa;
		bit [4:0]  pn;
		bit [7:0]  pd;
		bit        hlt;
		bit [13:0] hl;
		bit [3:0]  fl;
		bit [7:0]  acc;
	} outcome_t;

	typedef struct {
		bit [7:0] op, lo, hi, mb, pin;
		bit       irq;
		bit       typed;
		bit [13:0] pc;
		bit [7:0]  acc;
		bit [3:0]  fl;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [3:0]  m_tuser;

	// predictor state
	bit [7:0]  regs [0:6];
	flags_t    flg;
	bit [13:0] pc_stack [0:7];
	bit [2:0]  sp;

	outcome_t pending [$];
	int       errors = 0;
	int       accepted = 0;
	bit       hold = 1'b0;
	bit       calm_out = 1'b0;

	eight_bit_cpu_execute_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic bit [7:0] opc(input bit [1:0] grp, input bit [2:0] d, input bit [2:0] s);
		return {grp, d, s};
	endfunction

	function automatic bit [13:0] hl_now();
		return {regs[REG_H][5:0], regs[REG_L]};
	endfunction

	task automatic bump_pc(input bit irq);
		if (!irq)
			pc_stack[sp] = pc_stack[sp] + 14'd1;
	endtask

	task automatic set_szp(input bit [7:0] v);
		flg.zero   = (v == 8'd0);
		flg.sign   = v[7];
		flg.parity = ~^v;
	endtask

	task automatic run_alu(input alu_op_t op, input bit [7:0] b);
		bit [8:0] a9, r;
		a9 = {1'b0, regs[REG_A]};
		case (op)
			ALU_ADD: r = a9 + b;
			ALU_ADC: r = a9 + b + flg.carry;
			ALU_SUB, ALU_CMP: r = a9 - b;
			ALU_SBB: r = a9 - b - flg.carry;
			ALU_AND: r = a9 & {1'b0, b};
			ALU_XOR: r = a9 ^ {1'b0, b};
			default: r = a9 | {1'b0, b};
		endcase
		if (op != ALU_CMP)
			regs[REG_A] = r[7:0];
		set_szp(r[7:0]);
		flg.carry = r[8];
	endtask

	function automatic bit cond_met(input bit [7:0] o);
		bit f;
		f = flg[o[4:3]];
		if (o[2])
			return 1'b1;
		return o[5] ? f : !f;
	endfunction

	// execute one instruction on the predictor state
	task automatic execute(input bit [39:0] d, input bit irq, output outcome_t r);
		bit [7:0]  o, lo, hi, mb, pin, a, v;
		bit [2:0]  dst, src;
		bit [13:0] hlb;
		bit        take;
		{pin, mb, hi, lo, o} = d;
		dst = o[5:3];
		src = o[2:0];
		a = regs[REG_A];
		hlb = hl_now();
		r = '{default: 0};
		bump_pc(irq);
		case (o[7:6])
			GRP_MISC: begin
				if (src == SUB_INR || src == SUB_DCR) begin
					if (dst == REG_A) begin
						r.hlt = 1'b1;
					end else if (dst != REG_M) begin
						v = (src == SUB_DCR) ? regs[dst] - 8'd1 : regs[dst] + 8'd1;
						regs[dst] = v;
						set_szp(v);
					end
				end else if (src == SUB_ROT) begin
					case (dst)
						3'd0: begin regs[REG_A] = {a[6:0], a[7]}; flg.carry = a[7]; end
						3'd1: begin regs[REG_A] = {a[0], a[7:1]}; flg.carry = a[0]; end
						3'd2: begin regs[REG_A] = {a[6:0], flg.carry}; flg.carry = a[7]; end
						3'd3: begin regs[REG_A] = {flg.carry, a[7:1]}; flg.carry = a[0]; end
						default: ;
					endcase
				end else if (src == SUB_RET || src == SUB_RETU) begin
					if (cond_met(o))
						sp = sp - 3'd1;
				end else if (src == SUB_ALUI) begin
					bump_pc(irq);
					run_alu(alu_op_t'(dst), lo);
				end else if (src == SUB_RST) begin
					sp = sp + 3'd1;
					pc_stack[sp] = {6'd0, o & 8'h38};
				end else begin
					bump_pc(irq);
					if (dst == REG_M) begin
						r.mw = 1'b1;
						r.wd = lo;
					end else begin
						regs[dst] = lo;
					end
				end
			end
			GRP_JMP: begin
				if (o[0]) begin
					r.pn = o[5:1];
					r.pd = a;
					if (o[5:4] == 2'd0) begin
						r.pa = PORT_IN;
						regs[REG_A] = pin;
					end else begin
						r.pa = PORT_OUT;
					end
				end else begin
					take = cond_met(o);
					bump_pc(irq);
					bump_pc(irq);
					if (take) begin
						if (o[1])
							sp = sp + 3'd1;
						pc_stack[sp] = {hi[5:0], lo};
					end
				end
			end
			GRP_ALU: run_alu(alu_op_t'(dst), src == REG_M ? mb : regs[src]);
			default: begin
				if (dst == REG_M && src == REG_M) begin
					r.hlt = 1'b1;
				end else begin
					v = (src == REG_M) ? mb : regs[src];
					if (dst == REG_M) begin
						r.mw = 1'b1;
						r.wd = v;
					end else begin
						regs[dst] = v;
					end
				end
			end
		endcase
		r.pc = pc_stack[sp];
		r.wa = r.mw ? hlb : 14'd0;
		r.hl = hl_now();
		r.fl = flg;
		r.acc = regs[REG_A];
	endtask

	task automatic send(input bit [39:0] d, input bit irq, input bit gaps, output outcome_t r);
		while (gaps && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= irq;
		do @(posedge clk); while (!s_tready);
		execute(d, irq, r);
		accepted++;
	endtask

	task automatic chk(input string nm, input int unsigned e, input int unsigned g);
		if (e != g) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, g);
			errors++;
		end
	endtask

	// result side: check every item and drive ready
	always @(posedge clk) begin
		outcome_t e;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				e = pending.pop_front();
				chk("next_pc", e.pc, m_tdata[13:0]);
				chk("write_address", e.wa, m_tdata[27:14]);
				chk("write_data", e.wd, m_tdata[35:28]);
				chk("port_number", e.pn, m_tdata[40:36]);
				chk("port_out_data", e.pd, m_tdata[48:41]);
				chk("hl_pointer", e.hl, m_tdata[62:49]);
				chk("flag_bits", e.fl, m_tdata[66:63]);
				chk("accumulator", e.acc, m_tdata[74:67]);
				chk("mem_write", e.mw, m_tuser[0]);
				chk("port_access", e.pa, m_tuser[2:1]);
				chk("halted", e.hlt, m_tuser[3]);
			end
		end
		if (arst_n)
			m_tready <= hold ? 1'b0 : (calm_out ? 1'b1 : ($urandom_range(99) >= 33));
	end

	// long receiver hold-off so the core fills and stalls its input
	initial begin
		wait (accepted >= 100);
		@(posedge clk);
		hold <= 1'b1;
		repeat (80) @(posedge clk);
		hold <= 1'b0;
		wait (accepted >= 200);
		@(posedge clk);
		calm_out <= 1'b1;
		wait (accepted >= 300);
		@(posedge clk);
		calm_out <= 1'b0;
	end

	initial begin
		row_t     tbl [$];
		row_t     t;
		outcome_t r;
		bit [39:0] d;
		bit        irq;
		foreach (regs[i]) regs[i] = '0;
		foreach (pc_stack[i]) pc_stack[i] = '0;
		flg = '0;
		sp = '0;
		// op, lo, hi, mem, port, irq, typed, pc, acc, flags
		tbl = '{
			'{opc(GRP_MISC, REG_A, SUB_INR), 0, 0, 0, 0, 0, 1, 14'd1, 8'h00, 4'h0},
			'{opc(GRP_MISC, REG_A, SUB_MVI), 8'hFF, 0, 0, 0, 0, 1, 14'd3, 8'hFF, 4'h0},
			'{opc(GRP_MISC, ALU_ADD, SUB_ALUI), 8'h01, 0, 0, 0, 0, 1, 14'd5, 8'h00, 4'hB},
			'{opc(GRP_MISC, ALU_SUB, SUB_ALUI), 8'h01, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, REG_H, SUB_MVI), 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, REG_L, SUB_MVI), 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MOV, REG_M, REG_A), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MOV, REG_A, REG_M), 0, 0, 8'hAA, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, REG_M, SUB_MVI), 8'h5A, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd1, SUB_INR), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd1, SUB_DCR), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, REG_M, SUB_INR), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd0, SUB_ROT), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd1, SUB_ROT), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd2, SUB_ROT), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd3, SUB_ROT), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd5, SUB_ROT), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_JMP, 3'd0, 3'd6), 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd0, SUB_RETU), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MISC, 3'd7, SUB_RST), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_JMP, 3'd0, 3'd4), 8'h34, 8'hC2, 0, 0, 1, 0, 0, 0, 0},
			'{opc(GRP_JMP, 3'd0, 3'd0), 8'h12, 8'h01, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_JMP, 3'd0, 3'd1), 0, 0, 0, 8'hC3, 0, 0, 0, 0, 0},
			'{opc(GRP_JMP, 3'd7, 3'd7), 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_ALU, ALU_CMP, REG_M), 0, 0, 8'h80, 0, 0, 0, 0, 0, 0},
			'{opc(GRP_MOV, REG_M, REG_M), 0, 0, 0, 0, 0, 0, 0, 0, 0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tbl[i]) begin
			t = tbl[i];
			send({t.pin, t.mb, t.hi, t.lo, t.op}, t.irq, 1'b0, r);
			if (t.typed) begin
				r.pc = t.pc;
				r.acc = t.acc;
				r.fl = t.fl;
			end
			pending.push_back(r);
		end
		for (int n = 0; n < 400; n++) begin
			d = {8'($urandom()), 32'($urandom())};
			irq = ($urandom_range(9) == 0);
			send(d, irq, !(n >= 150 && n < 230), r);
			pending.push_back(r);
		end
		s_tvalid <= 1'b0;
		wait (pending.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
